/* rtl/fvn_pkg.sv */
`timescale 1ns / 1ps
package fvn_pkg;

    localparam int MAX_OCTAVES_DEF   = 8;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W = 32;
    localparam int SUM_W   = 64;
    localparam int OUT_W   = 40;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;

    // register index map of the configuration port
    typedef enum logic [CIDX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_SEED     = 3'd1,
        CFG_OCTAVES  = 3'd2,
        CFG_PERSIST  = 3'd3,
        CFG_AMP      = 3'd4,
        CFG_INVSCALE = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] MODE_PLAIN      = 2'd0;
    localparam logic [1:0] MODE_ABS        = 2'd1;
    localparam logic [1:0] MODE_CONTOUR    = 2'd2;
    localparam logic [1:0] MODE_CONTOUR_YZ = 2'd3;

    localparam logic [31:0] WEIGHT_ONE = 32'd4096;

    // per-lane settings handed from the top level to each octave lane
    typedef struct packed {
        logic        abs_mode;
        logic        active;
        logic [31:0] seed;
        logic [31:0] weight;
    } t_lane_cfg;

endpackage

/* rtl/fvn_pipe_ctrl.sv */
`timescale 1ns / 1ps
module fvn_pipe_ctrl #(
    parameter int NUM_STAGES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    output logic [NUM_STAGES-1:0] o_en,
    output logic                  o_out_valid
);
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        o_en[NUM_STAGES-1] = ~r_vld[NUM_STAGES-1] | i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            o_en[k] = ~r_vld[k] | o_en[k+1];
        end
        n_vld = r_vld;
        if (o_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (o_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_out_valid = r_vld[NUM_STAGES-1];

endmodule

/* rtl/fvn_weight_gen.sv */
`timescale 1ns / 1ps
module fvn_weight_gen #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [15:0]                 i_persist,
    output logic                        o_busy,
    output logic [MAX_OCTAVES-1:0][31:0] o_weight
);
    import fvn_pkg::*;

    localparam int IDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

    logic                         r_busy;
    logic [IDX_W-1:0]             r_idx;
    logic [31:0]                  r_cur;
    logic [MAX_OCTAVES-1:0][31:0] r_w;
    logic [48:0]                  w_prod;
    logic [36:0]                  w_shift;
    logic [31:0]                  n_cur;

    // g' = min(round(g * p / 4096), 2^32-1)
    always_comb begin
        w_prod  = 49'(r_cur) * 49'(i_persist) + 49'd2048;
        w_shift = w_prod[48:12];
        n_cur   = (w_shift[36:32] != '0) ? 32'hffff_ffff : w_shift[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_cur  <= WEIGHT_ONE;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_cur  <= WEIGHT_ONE;
        end else if (r_busy) begin
            r_cur <= n_cur;
            if (r_idx == IDX_W'(MAX_OCTAVES - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            r_w[r_idx] <= r_cur;
        end
    end

    assign o_busy   = r_busy;
    assign o_weight = r_w;

    a_first_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_w[0] == WEIGHT_ONE))
        else $error("octave 0 weight is not 1.0");

endmodule

/* rtl/fvn_octave.sv */
`timescale 1ns / 1ps
module fvn_octave #(
    parameter int FRACTION_BITS = 16,
    parameter int OCTAVE        = 0
) (
    input  logic                          i_clk,
    input  logic [8:0]                    i_en,
    input  logic signed [63:0]            i_px,
    input  logic signed [63:0]            i_py,
    input  logic signed [63:0]            i_pz,
    input  fvn_pkg::t_lane_cfg            i_cfg,
    output logic signed [fvn_pkg::SUM_W-1:0] o_term
);
    import fvn_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int LW = 32 + F + 3;
    localparam logic [F:0]           ONE_T = {1'b1, {F{1'b0}}};
    localparam logic signed [LW-1:0] HALF  = LW'(64'd1 << (F - 1));

    localparam logic [31:0] HX   = 32'd1619;
    localparam logic [31:0] HY   = 32'd31337;
    localparam logic [31:0] HZ   = 32'd52591;
    localparam logic [31:0] HS   = 32'd1013;
    localparam logic [31:0] HM1  = 32'd60493;
    localparam logic [31:0] HA1  = 32'd19990303;
    localparam logic [31:0] HA2  = 32'd1376312589;
    localparam logic [31:0] MASK = 32'h7fff_ffff;
    localparam logic signed [32:0] VONE = 33'sd1073741824;

    // cell and fraction; an integer point that is not positive takes the cell below
    function automatic logic [32+F:0] split(input logic signed [63:0] p);
        logic [31:0] c;
        logic [F:0]  t;
        begin
            c = p[F+31:F];
            t = {1'b0, p[F-1:0]};
            if ((p[F-1:0] == '0) && (p[63] || (p[63:F] == '0))) begin
                c = c - 32'd1;
                t = ONE_T;
            end
            return {c, t};
        end
    endfunction

    function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [F:0]         t);
        logic signed [F+1:0]  wa;
        logic signed [F+1:0]  wb;
        logic signed [LW-1:0] acc;
        begin
            wa  = $signed({1'b0, ONE_T - t});
            wb  = $signed({1'b0, t});
            acc = LW'(a) * LW'(wa) + LW'(b) * LW'(wb) + HALF;
            return acc[F+31:F];
        end
    endfunction

    // stage 0: octave shift and lattice split
    logic [2:0][31:0]       r_cell;
    logic [6:0][2:0][F:0]   r_tq;
    logic [32+F:0]          w_sx, w_sy, w_sz;

    always_comb begin
        w_sx = split(i_px <<< OCTAVE);
        w_sy = split(i_py <<< OCTAVE);
        w_sz = split(i_pz <<< OCTAVE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_cell[0] <= w_sx[32+F:F+1];
            r_cell[1] <= w_sy[32+F:F+1];
            r_cell[2] <= w_sz[32+F:F+1];
            r_tq[0][0] <= w_sx[F:0];
            r_tq[0][1] <= w_sy[F:0];
            r_tq[0][2] <= w_sz[F:0];
        end
        for (int s = 1; s < 7; s++) begin
            if (i_en[s]) begin
                r_tq[s] <= r_tq[s-1];
            end
        end
    end

    // stage 1: linear mix of the eight corners, corner k = x + 2y + 4z
    logic [7:0][30:0] r_n1;
    logic [7:0][30:0] w_n1;

    always_comb begin
        logic [1:0][31:0] mx, my, mz;
        logic [31:0] ms, lin;
        mx[0] = HX * r_cell[0];
        my[0] = HY * r_cell[1];
        mz[0] = HZ * r_cell[2];
        mx[1] = mx[0] + HX;
        my[1] = my[0] + HY;
        mz[1] = mz[0] + HZ;
        ms    = HS * i_cfg.seed;
        for (int k = 0; k < 8; k++) begin
            lin     = (mx[k%2] + my[(k/2)%2] + mz[k/4] + ms) & MASK;
            w_n1[k] = lin[30:0] ^ (lin[30:0] >> 13);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_n1 <= w_n1;
        end
    end

    // stages 2 to 4: polynomial part of the hash, one multiply each
    logic [7:0][30:0] r_n2, r_n3;
    logic [7:0][31:0] r_nn, r_m;
    logic signed [7:0][31:0] r_val;

    always_ff @(posedge i_clk) begin
        logic [31:0] h;
        logic signed [32:0] d;
        for (int k = 0; k < 8; k++) begin
            if (i_en[2]) begin
                r_nn[k] <= {1'b0, r_n1[k]} * {1'b0, r_n1[k]};
                r_n2[k] <= r_n1[k];
            end
            if (i_en[3]) begin
                r_m[k]  <= r_nn[k] * HM1 + HA1;
                r_n3[k] <= r_n2[k];
            end
            if (i_en[4]) begin
                h = ({1'b0, r_n3[k]} * r_m[k] + HA2) & MASK;
                d = VONE - $signed({1'b0, h});
                r_val[k] <= d[31:0];
            end
        end
    end

    // stages 5 to 7: interpolate along x, y, z
    logic signed [3:0][31:0] r_lx;
    logic signed [1:0][31:0] r_ly;
    logic signed [31:0]      r_v;
    logic signed [31:0]      w_vz;
    logic signed [SUM_W:0]   w_wt;
    logic signed [SUM_W-1:0] r_term;

    assign w_vz = lerp(r_ly[0], r_ly[1], r_tq[6][2]);
    assign w_wt = (SUM_W+1)'(r_v) * (SUM_W+1)'($signed({1'b0, i_cfg.weight}))
                + (SUM_W+1)'(2048);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            for (int k = 0; k < 4; k++) begin
                r_lx[k] <= lerp(r_val[2*k], r_val[2*k+1], r_tq[4][0]);
            end
        end
        if (i_en[6]) begin
            r_ly[0] <= lerp(r_lx[0], r_lx[1], r_tq[5][1]);
            r_ly[1] <= lerp(r_lx[2], r_lx[3], r_tq[5][1]);
        end
        if (i_en[7]) begin
            r_v <= (i_cfg.abs_mode && w_vz[31]) ? -w_vz : w_vz;
        end
        // stage 8: octave weight
        if (i_en[8]) begin
            r_term <= i_cfg.active ? SUM_W'(w_wt >>> 12) : '0;
        end
    end

    assign o_term = r_term;

endmodule

/* rtl/fractal_value_noise_3d_core.sv */
`timescale 1ns / 1ps
// Throughput: one beat per cycle outside a weight table build; every stage has its own valid bit
// and a stage moves whenever it is empty or the stage after it moves.
// Reset (synchronous, active low) empties the pipeline, loads register defaults and starts
// the octave weight table build, with s_axis_tready low until it ends; rerun on
// every persistence write.
module fractal_value_noise_3d_core #(
    parameter int MAX_OCTAVES   = fvn_pkg::MAX_OCTAVES_DEF,
    parameter int FRACTION_BITS = fvn_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream: coord_x [31:0], coord_y [63:32], coord_z [95:64]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [3*fvn_pkg::COORD_W-1:0] s_axis_tdata,
    // output stream: noise_value [39:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [fvn_pkg::OUT_W-1:0]     m_axis_tdata,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fvn_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [fvn_pkg::CFG_W-1:0]     i_cfg_data
);
    import fvn_pkg::*;

    // tree over octave lanes, padded to a power of two
    localparam int TREE_LV = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int LEAVES  = 1 << TREE_LV;

    // stage numbering
    localparam int ST_MUL   = 0;
    localparam int ST_LANE  = 1;             // nine lane stages
    localparam int ST_TREE  = ST_LANE + 9;
    localparam int ST_A16   = ST_TREE + TREE_LV;
    localparam int ST_PROD  = ST_A16 + 1;
    localparam int ST_OUT   = ST_PROD + 1;
    localparam int NS       = ST_OUT + 1;
    localparam int SHIFT    = 40 - FRACTION_BITS;

    localparam logic signed [40:0] A16_LIM = 41'sh0FF_FFFF_FFFF;
    localparam logic signed [48:0] RES_MAX = 49'sh00_007F_FFFF_FFFF;
    localparam logic signed [48:0] RES_MIN = -49'sh00_0080_0000_0000;
    localparam logic signed [65:0] C_ONE   = 66'sh1_0000_0000;

    // ---------------- configuration registers ----------------
    logic [1:0]         r_mode;
    logic [31:0]        r_seed;
    logic [3:0]         r_oct;
    logic [15:0]        r_persist;
    logic signed [23:0] r_amp;
    logic [31:0]        r_inv;
    logic               w_cfg_we;
    logic               w_persist_we;

    assign o_cfg_ready  = 1'b1;
    assign w_cfg_we     = i_cfg_valid;
    assign w_persist_we = w_cfg_we && (i_cfg_index == CFG_PERSIST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_PLAIN;
            r_seed    <= '0;
            r_oct     <= 4'd1;
            r_persist <= 16'd2048;
            r_amp     <= 24'sd65536;
            r_inv     <= 32'd16777216;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:     r_mode    <= i_cfg_data[1:0];
                CFG_SEED:     r_seed    <= i_cfg_data;
                CFG_OCTAVES:  r_oct     <= i_cfg_data[3:0];
                CFG_PERSIST:  r_persist <= i_cfg_data[15:0];
                CFG_AMP:      r_amp     <= i_cfg_data[23:0];
                CFG_INVSCALE: r_inv     <= i_cfg_data;
                default: ;    // unmapped index: dropped
            endcase
        end
    end

    // ---------------- octave weights ----------------
    logic                         w_busy;
    logic [MAX_OCTAVES-1:0][31:0] w_weight;

    fvn_weight_gen #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_weight (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_persist_we),
        .i_persist (r_persist),
        .o_busy    (w_busy),
        .o_weight  (w_weight)
    );

    // ---------------- pipeline control ----------------
    logic [NS-1:0] w_en;

    fvn_pipe_ctrl #(
        .NUM_STAGES (NS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid && !w_busy),
        .i_out_ready (m_axis_tready),
        .o_en        (w_en),
        .o_out_valid (m_axis_tvalid)
    );

    assign s_axis_tready = w_en[ST_MUL] && !w_busy;

    // ---------------- stage 0: coordinate times reciprocal scale ----------------
    logic signed [2:0][63:0] r_pos;

    always_ff @(posedge i_clk) begin
        logic signed [64:0] full;
        if (w_en[ST_MUL]) begin
            for (int a = 0; a < 3; a++) begin
                full = 65'($signed(s_axis_tdata[a*COORD_W +: COORD_W]))
                     * 65'($signed({1'b0, r_inv}));
                r_pos[a] <= full[63:0];
            end
        end
    end

    // floor to FRACTION_BITS fraction bits, swap y/z in the swapped contour mode
    logic signed [63:0] w_sx, w_sy, w_sz;

    always_comb begin
        w_sx = $signed(r_pos[0]) >>> SHIFT;
        w_sy = $signed(r_pos[1]) >>> SHIFT;
        w_sz = $signed(r_pos[2]) >>> SHIFT;
        if (r_mode == MODE_CONTOUR_YZ) begin
            w_sy = $signed(r_pos[2]) >>> SHIFT;
            w_sz = $signed(r_pos[1]) >>> SHIFT;
        end
    end

    // ---------------- octave lanes ----------------
    logic signed [SUM_W-1:0] w_node [1:2*LEAVES-1];

    for (genvar i = 0; i < LEAVES; i++) begin : g_lane
        if (i < MAX_OCTAVES) begin : g_real
            t_lane_cfg w_lcfg;
            assign w_lcfg.abs_mode = (r_mode == MODE_ABS);
            assign w_lcfg.active   = (32'(r_oct) > i);
            assign w_lcfg.seed     = r_seed + 32'(i);
            assign w_lcfg.weight   = w_weight[i];

            fvn_octave #(
                .FRACTION_BITS (FRACTION_BITS),
                .OCTAVE        (i)
            ) u_oct (
                .i_clk  (i_clk),
                .i_en   (w_en[ST_LANE +: 9]),
                .i_px   (w_sx),
                .i_py   (w_sy),
                .i_pz   (w_sz),
                .i_cfg  (w_lcfg),
                .o_term (w_node[LEAVES + i])
            );
        end else begin : g_pad
            assign w_node[LEAVES + i] = '0;
        end
    end

    // ---------------- registered adder tree, heap order, root at node 1 ----------------
    for (genvar j = 1; j < LEAVES; j++) begin : g_tree
        localparam int DEPTH = $clog2(j + 1) - 1;
        localparam int STG   = ST_TREE + TREE_LV - 1 - DEPTH;
        logic signed [SUM_W-1:0] r_sum;
        always_ff @(posedge i_clk) begin
            if (w_en[STG]) begin
                r_sum <= w_node[2*j] + w_node[2*j+1];
            end
        end
        assign w_node[j] = r_sum;
    end

    // ---------------- output scaling ----------------
    logic signed [40:0] r_a16;
    logic signed [64:0] r_prod;
    logic [OUT_W-1:0]   r_out;
    logic signed [SUM_W-1:0] w_rnd;
    logic signed [SUM_W-15:0] w_a16w;
    logic signed [65:0] w_c;
    logic signed [48:0] w_res;

    always_comb begin
        w_rnd  = w_node[1] + SUM_W'(8192);
        w_a16w = w_rnd[SUM_W-1:14];
        w_c    = r_prod[64] ? -66'(r_prod) : 66'(r_prod);
        if (r_mode[1]) begin
            // contour: 1 - |P|, never below zero
            if (w_c >= C_ONE) begin
                w_res = '0;
            end else begin
                w_res = 49'((C_ONE - w_c + 66'sd32768) >>> 16);
            end
        end else begin
            w_res = 49'((66'(r_prod) + 66'sd32768) >>> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_A16]) begin
            priority if (w_a16w > (SUM_W-14)'(A16_LIM)) begin
                r_a16 <= A16_LIM;
            end else if (w_a16w < -(SUM_W-14)'(A16_LIM)) begin
                r_a16 <= -A16_LIM;
            end else begin
                r_a16 <= w_a16w[40:0];
            end
        end
        if (w_en[ST_PROD]) begin
            r_prod <= 65'(r_a16) * 65'(r_amp);
        end
        if (w_en[ST_OUT]) begin
            priority if (w_res > RES_MAX) begin
                r_out <= RES_MAX[OUT_W-1:0];
            end else if (w_res < RES_MIN) begin
                r_out <= RES_MIN[OUT_W-1:0];
            end else begin
                r_out <= w_res[OUT_W-1:0];
            end
        end
    end

    assign m_axis_tdata = r_out;

    // ---------------- checks ----------------
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("input taken during weight build");

    a_contour_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_mode[1]) |-> !m_axis_tdata[OUT_W-1])
        else $error("negative contour output");

    // stages run empty with unknown data right after reset
    a_a16_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(w_en[ST_A16]) && !$isunknown(r_a16)) |-> (r_a16 != -41'sh100_0000_0000))
        else $error("A16 outside clamp");

endmodule
